[rtl/irpd_pkg.sv]
// Shared types and constants for the infrared pulse-distance decoder.
// No dependencies; used by every module of the block.
package irpd_pkg;

    localparam int GAP_BITS     = 32;
    localparam int KEY_BITS     = 16;
    localparam int EDGE_BITS    = 7;
    localparam int CFG_IDX_BITS = 3;

    // Frame edge positions
    localparam logic [EDGE_BITS-1:0] LEADER_MARK_EDGE  = 7'd2;
    localparam logic [EDGE_BITS-1:0] LEADER_SPACE_EDGE = 7'd3;
    localparam logic [EDGE_BITS-1:0] REPEAT_EDGE       = 7'd4;
    localparam logic [EDGE_BITS-1:0] FIRST_BIT_EDGE    = 7'd5;
    localparam logic [EDGE_BITS-1:0] LAST_BIT_EDGE     = 7'd67;
    localparam logic [EDGE_BITS-1:0] FRAME_EDGES       = 7'd68;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT_GAP      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEADER_MIN       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEADER_MAX       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_SPACE_MAX = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_THRESHOLD    = 3'd4;

    // Register reset values
    localparam logic [GAP_BITS-1:0] RST_TIMEOUT_GAP      = 32'd30000000;
    localparam logic [GAP_BITS-1:0] RST_LEADER_MIN       = 32'd8000000;
    localparam logic [GAP_BITS-1:0] RST_LEADER_MAX       = 32'd10000000;
    localparam logic [GAP_BITS-1:0] RST_REPEAT_SPACE_MAX = 32'd3000000;
    localparam logic [GAP_BITS-1:0] RST_ONE_THRESHOLD    = 32'd1000000;

    // Gap queue between front and back
    localparam int GAP_Q_DEPTH    = 2;
    localparam int GAP_Q_PTR_BITS = $clog2(GAP_Q_DEPTH);
    localparam int GAP_Q_CNT_BITS = $clog2(GAP_Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_NEW_KEY    = 2'd1,
        ST_REPEAT_KEY = 2'd2,
        ST_CHECK_ERR  = 2'd3
    } status_t;

    typedef struct packed {
        logic [GAP_BITS-1:0] timeout_gap;
        logic [GAP_BITS-1:0] leader_min;
        logic [GAP_BITS-1:0] leader_max;
        logic [GAP_BITS-1:0] repeat_space_max;
        logic [GAP_BITS-1:0] one_threshold;
    } cfg_t;

    // Queue write side and read side
    typedef struct packed {
        logic                push;
        logic [GAP_BITS-1:0] gap;
    } gap_wr_t;

    typedef struct packed {
        logic                valid;
        logic [GAP_BITS-1:0] gap;
    } gap_rd_t;

endpackage

[rtl/irpd_front.sv]
// Front end: accepts edge timestamps and turns them into saturated gaps.
// Depends on irpd_pkg.
module irpd_front #(
    parameter int TIME_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_BITS-1:0]  edge_time,
    input  logic                  q_full,
    output irpd_pkg::gap_wr_t     q_wr
);

    logic [TIME_BITS-1:0]          previous_time_reg;
    logic [TIME_BITS-1:0]          diff;
    logic [irpd_pkg::GAP_BITS-1:0] gap;
    logic                          accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign diff     = edge_time - previous_time_reg;

    generate
        if (TIME_BITS > irpd_pkg::GAP_BITS) begin : g_sat
            assign gap = (|diff[TIME_BITS-1:irpd_pkg::GAP_BITS]) ? '1
                                                                : diff[irpd_pkg::GAP_BITS-1:0];
        end else begin : g_nosat
            assign gap = diff;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_time_reg <= '0;
        end
        else if (accept)
        begin
            previous_time_reg <= edge_time;
        end
    end

    assign q_wr.push = accept;
    assign q_wr.gap  = gap;

endmodule

[rtl/irpd_gap_fifo.sv]
// Short queue of gaps between front and back.
// Depends on irpd_pkg.
module irpd_gap_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  irpd_pkg::gap_wr_t q_wr,
    input  logic              pop,
    output irpd_pkg::gap_rd_t q_rd,
    output logic              full
);

    logic [irpd_pkg::GAP_BITS-1:0]       gap_mem_reg [irpd_pkg::GAP_Q_DEPTH];
    logic [irpd_pkg::GAP_Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [irpd_pkg::GAP_Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [irpd_pkg::GAP_Q_CNT_BITS-1:0] count_reg;
    logic [irpd_pkg::GAP_Q_CNT_BITS-1:0] count_next;
    logic                                do_pop;

    assign full       = count_reg == irpd_pkg::GAP_Q_CNT_BITS'(irpd_pkg::GAP_Q_DEPTH);
    assign q_rd.valid = count_reg != '0;
    assign q_rd.gap   = gap_mem_reg[rd_ptr_reg];
    assign do_pop     = pop && q_rd.valid;

    always_comb
    begin
        count_next = count_reg;
        if (q_wr.push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!q_wr.push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            gap_mem_reg[wr_ptr_reg] <= q_wr.gap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_wr.push)
                wr_ptr_reg <= (wr_ptr_reg == irpd_pkg::GAP_Q_PTR_BITS'(irpd_pkg::GAP_Q_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == irpd_pkg::GAP_Q_PTR_BITS'(irpd_pkg::GAP_Q_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/irpd_back.sv]
// Back end: frame decoder working on gaps, with the result output register.
// Depends on irpd_pkg.
module irpd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  irpd_pkg::cfg_t                cfg,
    input  irpd_pkg::gap_rd_t             q_rd,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [irpd_pkg::KEY_BITS-1:0] key_code
);

    logic [irpd_pkg::EDGE_BITS-1:0] edge_count_reg, edge_count_next;
    logic [irpd_pkg::GAP_BITS-1:0]  leader_mark_reg, leader_mark_next;
    logic [irpd_pkg::GAP_BITS-1:0]  frame_bits_reg, frame_bits_next;
    logic [irpd_pkg::KEY_BITS-1:0]  last_key_reg, last_key_next;
    logic                           space_short_reg, space_short_next;
    logic                           out_valid_reg;
    irpd_pkg::status_t              status_reg, status_next;
    logic [irpd_pkg::KEY_BITS-1:0]  key_reg, key_next;

    logic [irpd_pkg::EDGE_BITS-1:0] n;
    logic [4:0]                     bit_sel;
    logic [irpd_pkg::GAP_BITS-1:0]  gap;
    logic [7:0]                     addr_b, naddr_b, cmd_b, ncmd_b;

    assign pop = q_rd.valid && (!out_valid_reg || out_ready);
    assign gap = q_rd.gap;
    assign n   = edge_count_reg + 1'b1;
    assign bit_sel = 5'((n - irpd_pkg::FIRST_BIT_EDGE) >> 1);

    // Bytes of the finished frame; bit 31 was written on edge 67
    assign addr_b  = frame_bits_reg[7:0];
    assign naddr_b = frame_bits_reg[15:8];
    assign cmd_b   = frame_bits_reg[23:16];
    assign ncmd_b  = frame_bits_reg[31:24];

    always_comb
    begin
        edge_count_next  = edge_count_reg;
        leader_mark_next = leader_mark_reg;
        frame_bits_next  = frame_bits_reg;
        last_key_next    = last_key_reg;
        space_short_next = space_short_reg;
        status_next      = irpd_pkg::ST_INCOMPLETE;
        key_next         = '0;

        if (edge_count_reg != '0 && gap > cfg.timeout_gap)
        begin
            edge_count_next = 7'd1;
        end
        else
        begin
            edge_count_next = n;
            if (n == irpd_pkg::LEADER_MARK_EDGE)
                leader_mark_next = gap;
            else if (n == irpd_pkg::LEADER_SPACE_EDGE)
                space_short_next = gap < cfg.repeat_space_max;
            else if (n >= irpd_pkg::FIRST_BIT_EDGE && n <= irpd_pkg::LAST_BIT_EDGE && n[0])
                frame_bits_next[bit_sel] = gap > cfg.one_threshold;

            priority if (n == irpd_pkg::REPEAT_EDGE && leader_mark_reg > cfg.leader_min &&
                         leader_mark_reg < cfg.leader_max && space_short_reg)
            begin
                status_next     = irpd_pkg::ST_REPEAT_KEY;
                key_next        = last_key_reg;
                edge_count_next = '0;
            end
            else if (n >= irpd_pkg::FRAME_EDGES)
            begin
                if (addr_b == ~naddr_b && cmd_b == ~ncmd_b)
                begin
                    last_key_next = {addr_b, cmd_b};
                    status_next   = irpd_pkg::ST_NEW_KEY;
                    key_next      = {addr_b, cmd_b};
                end
                else
                begin
                    status_next = irpd_pkg::ST_CHECK_ERR;
                end
                edge_count_next = '0;
            end
            else
            begin
                status_next = irpd_pkg::ST_INCOMPLETE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg  <= '0;
            leader_mark_reg <= '0;
            frame_bits_reg  <= '0;
            last_key_reg    <= '0;
            space_short_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                edge_count_reg  <= edge_count_next;
                leader_mark_reg <= leader_mark_next;
                frame_bits_reg  <= frame_bits_next;
                last_key_reg    <= last_key_next;
                space_short_reg <= space_short_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            key_reg    <= key_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign key_code  = key_reg;

endmodule

[rtl/ir_pulse_distance_decoder_core.sv]
// Top level of the infrared pulse-distance (NEC style) remote decoder.
// Depends on irpd_pkg, irpd_front, irpd_gap_fifo and irpd_back.
//
// Each input transaction carries the timestamp of one receiver edge and
// produces exactly one result transaction (status, key_code). The front
// takes the gap to the previous edge (modulo 2^TIME_BITS, saturated to 32
// bits) and pushes it into a two-entry gap queue; the back pops one gap per
// cycle while the output register is free or read, runs the frame decoder
// (edge counter, leader mark/space, 32 data bits LSB first, complement check
// at edge 68, repeat detection at edge 4) and loads the output register.
// Throughput is one edge per cycle while results are taken; each edge passes
// through the queue entry, then the output register. in_ready drops only
// when the queue is full, so the input keeps flowing while a result waits.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 timeout_gap, 1 leader_min, 2 leader_max, 3 repeat_space_max,
// 4 one_threshold); other indexes are ignored. Write only when idle.
module ir_pulse_distance_decoder_core #(
    parameter int TIME_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Edge input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [TIME_BITS-1:0]              edge_time,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [irpd_pkg::KEY_BITS-1:0]     key_code,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [irpd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [irpd_pkg::GAP_BITS-1:0]     cfg_wdata
);

    irpd_pkg::cfg_t    cfg_reg;
    irpd_pkg::gap_wr_t q_wr;
    irpd_pkg::gap_rd_t q_rd;
    logic              q_full;
    logic              q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_gap      <= irpd_pkg::RST_TIMEOUT_GAP;
            cfg_reg.leader_min       <= irpd_pkg::RST_LEADER_MIN;
            cfg_reg.leader_max       <= irpd_pkg::RST_LEADER_MAX;
            cfg_reg.repeat_space_max <= irpd_pkg::RST_REPEAT_SPACE_MAX;
            cfg_reg.one_threshold    <= irpd_pkg::RST_ONE_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                irpd_pkg::CFG_TIMEOUT_GAP:      cfg_reg.timeout_gap      <= cfg_wdata;
                irpd_pkg::CFG_LEADER_MIN:       cfg_reg.leader_min       <= cfg_wdata;
                irpd_pkg::CFG_LEADER_MAX:       cfg_reg.leader_max       <= cfg_wdata;
                irpd_pkg::CFG_REPEAT_SPACE_MAX: cfg_reg.repeat_space_max <= cfg_wdata;
                irpd_pkg::CFG_ONE_THRESHOLD:    cfg_reg.one_threshold    <= cfg_wdata;
                default: ; // unused index
            endcase
        end
    end

    irpd_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .edge_time (edge_time),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    irpd_gap_fifo u_gap_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .q_rd  (q_rd),
        .full  (q_full)
    );

    irpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_rd      (q_rd),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .key_code  (key_code)
    );

endmodule

[rtl/irpd_checker.sv]
// Port-level checks for the decoder core, attached by bind.
// Depends on irpd_pkg and ir_pulse_distance_decoder_core.
module irpd_checker #(
    parameter int TIME_BITS = 48
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [TIME_BITS-1:0]          edge_time,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    status,
    input logic [irpd_pkg::KEY_BITS-1:0] key_code
);

    logic [2:0]                    pending_reg;
    logic [irpd_pkg::KEY_BITS-1:0] seen_key_reg;
    logic                          in_xact;
    logic                          out_xact;

    assign in_xact  = in_valid && in_ready;
    assign out_xact = out_valid && out_ready;

    // Transactions in flight, and the last new key delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            seen_key_reg <= '0;
        end
        else
        begin
            if (in_xact && !out_xact)
                pending_reg <= pending_reg + 1'b1;
            else if (!in_xact && out_xact)
                pending_reg <= pending_reg - 1'b1;
            if (out_xact && status == irpd_pkg::ST_NEW_KEY)
                seen_key_reg <= key_code;
        end
    end

    // Queue plus output register bound the items in flight
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more transactions in flight than the core can hold");

    // No result without an accepted edge behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result presented with no edge outstanding");

    // A repeat reports the last delivered key
    a_repeat_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == irpd_pkg::ST_REPEAT_KEY |-> key_code == seen_key_reg)
        else $error("repeat key differs from the last new key");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(key_code))
        else $error("stalled result changed");

    // Waiting edge holds until accepted
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(edge_time))
        else $error("waiting edge changed before it was accepted");

endmodule

bind ir_pulse_distance_decoder_core irpd_checker #(
    .TIME_BITS (TIME_BITS)
) u_irpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .edge_time (edge_time),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .key_code  (key_code)
);

[sim/ir_pulse_distance_decoder_core_tb.sv]
// Self-checking testbench for ir_pulse_distance_decoder_core.
// Depends on irpd_pkg and the decoder RTL; drives edges, checks every result
// against a cycle-free model of the NEC-style frame decoder kept in this file.
module ir_pulse_distance_decoder_core_tb;

    localparam int TB_TIME_BITS = 48;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 190;
    localparam int NUM_PHASES   = 7;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_DIRECTED = 23;
    localparam logic [irpd_pkg::GAP_BITS-1:0] GAP_MAX = '1;

    // Receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_FLOW     = 2'd0,
        RX_MOSTLY   = 2'd1,
        RX_SPARSE   = 2'd2,
        RX_PERIODIC = 2'd3
    } rx_mode_t;

    typedef struct packed {
        logic [1:0]                    st;
        logic [irpd_pkg::KEY_BITS-1:0] key;
    } key_result_t;

    // Directed row: time is absolute or a delta from the previous edge;
    // "fixed" rows carry a hand-written expected result.
    typedef struct packed {
        logic                          absolute;
        logic [TB_TIME_BITS-1:0]       value;
        logic                          fixed;
        irpd_pkg::status_t             st;
        logic [irpd_pkg::KEY_BITS-1:0] key;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [TB_TIME_BITS-1:0]           edge_time = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [1:0]                        status;
    logic [irpd_pkg::KEY_BITS-1:0]     key_code;
    logic                              cfg_we = 1'b0;
    logic [irpd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [irpd_pkg::GAP_BITS-1:0]     cfg_wdata = '0;

    ir_pulse_distance_decoder_core #(
        .TIME_BITS(TB_TIME_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .edge_time(edge_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .key_code (key_code),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model state and its copy of the registers
    // ------------------------------------------------------------------
    logic [irpd_pkg::GAP_BITS-1:0]  timeout_cfg      = irpd_pkg::RST_TIMEOUT_GAP;
    logic [irpd_pkg::GAP_BITS-1:0]  leader_min_cfg   = irpd_pkg::RST_LEADER_MIN;
    logic [irpd_pkg::GAP_BITS-1:0]  leader_max_cfg   = irpd_pkg::RST_LEADER_MAX;
    logic [irpd_pkg::GAP_BITS-1:0]  repeat_space_cfg = irpd_pkg::RST_REPEAT_SPACE_MAX;
    logic [irpd_pkg::GAP_BITS-1:0]  one_cfg          = irpd_pkg::RST_ONE_THRESHOLD;

    logic [irpd_pkg::EDGE_BITS-1:0] edge_cnt       = '0;
    logic [TB_TIME_BITS-1:0]        last_edge_time = '0;
    logic [irpd_pkg::GAP_BITS-1:0]  leader_gap     = '0;
    logic [irpd_pkg::GAP_BITS-1:0]  data_bits      = '0;
    logic [irpd_pkg::KEY_BITS-1:0]  last_key       = '0;
    logic                           space_short    = 1'b0;

    key_result_t expected_results [$];

    // Bookkeeping shared between the driver and the monitor
    logic                          in_taken  = 1'b0;
    logic                          pend_fixed = 1'b0;
    irpd_pkg::status_t             pend_st    = irpd_pkg::ST_INCOMPLETE;
    logic [irpd_pkg::KEY_BITS-1:0] pend_key   = '0;
    logic [TB_TIME_BITS-1:0]       stim_time  = '0;
    int                            burst_left = 1;
    int                            items_sent = 0;
    int                            results_checked = 0;
    int                            mismatches = 0;
    int                            new_keys = 0;
    int                            repeat_keys = 0;
    int                            check_errs = 0;
    int                            cycle_count = 0;

    // ------------------------------------------------------------------
    // Frame decoder model: one edge in, one (status, key) out
    // ------------------------------------------------------------------
    task automatic decode_edge(input logic [TB_TIME_BITS-1:0] t,
                               output irpd_pkg::status_t st,
                               output logic [irpd_pkg::KEY_BITS-1:0] key);
        logic [TB_TIME_BITS-1:0]       diff;
        logic [irpd_pkg::GAP_BITS-1:0] gap;
        int                            n;
        logic [7:0]                    addr_b, naddr_b, cmd_b, ncmd_b;
        diff = t - last_edge_time;
        // gaps saturate to 32 bits before any compare
        gap = (diff > TB_TIME_BITS'(GAP_MAX)) ? GAP_MAX : diff[irpd_pkg::GAP_BITS-1:0];
        last_edge_time = t;
        st  = irpd_pkg::ST_INCOMPLETE;
        key = '0;
        // timeout: this edge becomes the first of a new frame
        if (edge_cnt >= 1 && gap > timeout_cfg)
        begin
            edge_cnt = 1;
            return;
        end
        n = int'(edge_cnt) + 1;
        if (n == irpd_pkg::LEADER_MARK_EDGE)
            leader_gap = gap;
        else if (n == irpd_pkg::LEADER_SPACE_EDGE)
            space_short = gap < repeat_space_cfg;
        else if (n >= irpd_pkg::FIRST_BIT_EDGE && n <= irpd_pkg::LAST_BIT_EDGE && n[0])
            data_bits[(n - irpd_pkg::FIRST_BIT_EDGE) >> 1] = gap > one_cfg;

        if (n == irpd_pkg::REPEAT_EDGE && leader_gap > leader_min_cfg &&
            leader_gap < leader_max_cfg && space_short)
        begin
            st  = irpd_pkg::ST_REPEAT_KEY;
            key = last_key;
            n   = 0;
        end
        else if (n >= irpd_pkg::FRAME_EDGES)
        begin
            addr_b  = data_bits[7:0];
            naddr_b = data_bits[15:8];
            cmd_b   = data_bits[23:16];
            ncmd_b  = data_bits[31:24];
            if (addr_b == ~naddr_b && cmd_b == ~ncmd_b)
            begin
                last_key = {addr_b, cmd_b};
                st  = irpd_pkg::ST_NEW_KEY;
                key = last_key;
            end
            else
            begin
                st = irpd_pkg::ST_CHECK_ERR;
            end
            n = 0;
        end
        edge_cnt = n[irpd_pkg::EDGE_BITS-1:0];
    endtask

    // ------------------------------------------------------------------
    // Monitor: at each rising edge record accepted edges and check results
    // ------------------------------------------------------------------
    irpd_pkg::status_t             mon_st;
    logic [irpd_pkg::KEY_BITS-1:0] mon_key;
    key_result_t                   mon_exp;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken = 1'b0;
        end
        else
        begin
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                decode_edge(edge_time, mon_st, mon_key);
                // hand-written rows override the model, the model state still advances
                if (pend_fixed)
                    expected_results.push_back('{st: pend_st, key: pend_key});
                else
                    expected_results.push_back('{st: mon_st, key: mon_key});
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: status %0d key %h",
                             $time, status, key_code);
                    mismatches++;
                end
                else
                begin
                    mon_exp = expected_results.pop_front();
                    results_checked++;
                    case (mon_exp.st)
                        irpd_pkg::ST_NEW_KEY:    new_keys++;
                        irpd_pkg::ST_REPEAT_KEY: repeat_keys++;
                        irpd_pkg::ST_CHECK_ERR:  check_errs++;
                        default: ;
                    endcase
                    if (status !== mon_exp.st)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, mon_exp.st, status);
                        mismatches++;
                    end
                    if (key_code !== mon_exp.key)
                    begin
                        $display("%0t: key_code mismatch: expected %h, actual %h",
                                 $time, mon_exp.key, key_code);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL ir_pulse_distance_decoder_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: out_ready follows a pattern that changes now and then
    // ------------------------------------------------------------------
    rx_mode_t rx_mode = RX_FLOW;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(3, 0));
            rx_left = $urandom_range(200, 30);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FLOW:   out_ready <= 1'b1;
            RX_MOSTLY: out_ready <= ($urandom_range(3, 0) != 0);
            RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
            default:   out_ready <= ((rx_tick % 8) >= 3);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Present one edge at a falling edge and hold it until accepted; returns
    // at the falling edge after the accepting rising edge. Bursts of random
    // length with random gaps between them.
    task automatic send_edge(input logic [TB_TIME_BITS-1:0] t, input logic fixed,
                             input irpd_pkg::status_t st,
                             input logic [irpd_pkg::KEY_BITS-1:0] key);
        int idle;
        stim_time  = t;
        pend_fixed = fixed;
        pend_st    = st;
        pend_key   = key;
        in_valid  <= 1'b1;
        edge_time <= t;
        do @(negedge clk); while (!in_taken);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(12, 1);
            idle = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (idle > 0)
            begin
                in_valid <= 1'b0;
                repeat (idle) @(negedge clk);
            end
        end
    endtask

    task automatic send_gap(input logic [TB_TIME_BITS-1:0] g);
        send_edge(stim_time + g, 1'b0, irpd_pkg::ST_INCOMPLETE, '0);
    endtask

    // Random gap in [lo, hi], kept at or below the timeout so a frame survives;
    // an empty range gives any value.
    function automatic logic [irpd_pkg::GAP_BITS-1:0] pick_gap(
        input logic [irpd_pkg::GAP_BITS-1:0] lo,
        input logic [irpd_pkg::GAP_BITS-1:0] hi);
        logic [irpd_pkg::GAP_BITS-1:0] top;
        top = (hi > timeout_cfg) ? timeout_cfg : hi;
        if (lo > top)
            return $urandom;
        return $urandom_range(top, lo);
    endfunction

    // One frame: restart gap, then a repeat code, a full data frame (good,
    // corrupted or cut short) or a run of noise edges.
    task automatic run_frame();
        int                            kind;
        int                            stop_at;
        logic [7:0]                    addr_b, cmd_b;
        logic [31:0]                   word;
        logic [irpd_pkg::GAP_BITS-1:0] g;
        logic                          data_bit;
        logic [63:0]                   wide;
        kind    = $urandom_range(99, 0);
        addr_b  = $urandom;
        cmd_b   = $urandom;
        word    = {~cmd_b, cmd_b, ~addr_b, addr_b};
        stop_at = irpd_pkg::FRAME_EDGES;
        if (kind >= 70 && kind < 88)
        begin
            if ($urandom_range(1, 0) != 0)
                word ^= 32'd1 << $urandom_range(31, 0);
            else
                word = $urandom;
            if ($urandom_range(2, 0) == 0)
                stop_at = $urandom_range(int'(irpd_pkg::LAST_BIT_EDGE) - 1,
                                         int'(irpd_pkg::REPEAT_EDGE));
        end

        // leading gap past a non-maximal timeout; sometimes one that needs saturation
        if ($urandom_range(9, 0) == 0)
            send_gap(48'h1_0000_0000 + 48'($urandom));
        else if (timeout_cfg != GAP_MAX)
            send_gap(48'(timeout_cfg) + 48'd1 + 48'($urandom_range(1000, 0)));
        else
            send_gap(pick_gap('0, GAP_MAX));

        if (kind >= 88)
        begin
            repeat ($urandom_range(12, 1))
            begin
                wide = {$urandom, $urandom};
                case ($urandom_range(2, 0))
                    0:       send_gap(pick_gap('0, GAP_MAX));
                    1:       send_gap(48'(wide[31:0]));
                    default: send_gap(wide[TB_TIME_BITS-1:0]);
                endcase
            end
            return;
        end

        if (kind < 20)
        begin
            // repeat code: mark in window, short space, closing edge
            send_gap(pick_gap(leader_min_cfg + 1, leader_max_cfg - 1));
            send_gap(pick_gap('0, repeat_space_cfg - 1));
            send_gap(pick_gap('0, one_cfg));
            return;
        end

        if ($urandom_range(9, 0) < 7)
            send_gap(pick_gap(leader_min_cfg + 1, leader_max_cfg - 1));
        else
            send_gap(pick_gap('0, GAP_MAX));
        send_gap(pick_gap(repeat_space_cfg, GAP_MAX));
        for (int n = irpd_pkg::REPEAT_EDGE; n <= stop_at; n++)
        begin
            if (n % 2 != 0)
            begin
                data_bit = word[(n - irpd_pkg::FIRST_BIT_EDGE) / 2];
                // now and then sit right on the one/zero threshold
                if ($urandom_range(9, 0) == 0)
                    g = data_bit ? one_cfg + 1 : one_cfg;
                else
                    g = data_bit ? pick_gap(one_cfg + 1, GAP_MAX) : pick_gap('0, one_cfg);
            end
            else
            begin
                g = pick_gap('0, one_cfg);
            end
            send_gap(g);
        end
    endtask

    // Register write; the model copy is updated at once since the block is idle
    task automatic write_reg(input logic [irpd_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [irpd_pkg::GAP_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        case (idx)
            irpd_pkg::CFG_TIMEOUT_GAP:      timeout_cfg      = val;
            irpd_pkg::CFG_LEADER_MIN:       leader_min_cfg   = val;
            irpd_pkg::CFG_LEADER_MAX:       leader_max_cfg   = val;
            irpd_pkg::CFG_REPEAT_SPACE_MAX: repeat_space_cfg = val;
            irpd_pkg::CFG_ONE_THRESHOLD:    one_cfg          = val;
            default: ;
        endcase
    endtask

    // Stop sending and wait for every outstanding result plus pipeline slack
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed edges, all at reset register values
    // ------------------------------------------------------------------
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        // first edge after reset
        '{1'b1, 48'd0,              1'b1, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        // repeat code: mark 9M, space 2.25M, closing edge
        '{1'b0, 48'd9000000,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd2250000,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd560000,         1'b1, irpd_pkg::ST_REPEAT_KEY, 16'h0000},
        // top timestamp, then wrap to zero
        '{1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b1, 48'h0000_0000_0000, 1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        // gap of 2^32 saturates and times out
        '{1'b1, 48'h0001_0000_0000, 1'b1, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        // mark equal to the lower bound: no repeat
        '{1'b0, 48'd8000000,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd1000000,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd500,            1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        // one past the timeout
        '{1'b0, 48'd30000001,       1'b1, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        // space equal to the repeat bound: data frame continues
        '{1'b0, 48'd9999999,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd3000000,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd560000,         1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        // gap equal to the timeout is kept; bit gap at the threshold is zero
        '{1'b0, 48'd30000000,       1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd1000000,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd1000000,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd30000001,       1'b1, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        // repeat with the widest mark and space, zero closing gap
        '{1'b0, 48'd9999999,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd2999999,        1'b0, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b0, 48'd0,              1'b1, irpd_pkg::ST_REPEAT_KEY, 16'h0000},
        // alternating bit patterns, second one times out after saturation
        '{1'b1, 48'hAAAA_5555_AAAA, 1'b1, irpd_pkg::ST_INCOMPLETE, 16'h0000},
        '{1'b1, 48'h5555_AAAA_5555, 1'b1, irpd_pkg::ST_INCOMPLETE, 16'h0000}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t                      row;
        logic [TB_TIME_BITS-1:0]       t;
        logic [irpd_pkg::GAP_BITS-1:0] base;
        int                            target;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            row = directed_rows[i];
            t = row.absolute ? row.value : stim_time + row.value;
            send_edge(t, row.fixed, row.st, row.key);
        end
        wait_idle();

        // Phase 0 runs at reset values; later phases rewrite every register
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(irpd_pkg::CFG_TIMEOUT_GAP,      32'd5000);
                    write_reg(irpd_pkg::CFG_LEADER_MIN,       32'd800);
                    write_reg(irpd_pkg::CFG_LEADER_MAX,       32'd1000);
                    write_reg(irpd_pkg::CFG_REPEAT_SPACE_MAX, 32'd300);
                    write_reg(irpd_pkg::CFG_ONE_THRESHOLD,    32'd100);
                end
                2:
                begin
                    write_reg(irpd_pkg::CFG_TIMEOUT_GAP,      GAP_MAX);
                    write_reg(irpd_pkg::CFG_LEADER_MIN,       '0);
                    write_reg(irpd_pkg::CFG_LEADER_MAX,       GAP_MAX);
                    write_reg(irpd_pkg::CFG_REPEAT_SPACE_MAX, GAP_MAX);
                    write_reg(irpd_pkg::CFG_ONE_THRESHOLD,    '0);
                end
                3:
                begin
                    write_reg(irpd_pkg::CFG_TIMEOUT_GAP,      '0);
                    write_reg(irpd_pkg::CFG_LEADER_MIN,       GAP_MAX);
                    write_reg(irpd_pkg::CFG_LEADER_MAX,       '0);
                    write_reg(irpd_pkg::CFG_REPEAT_SPACE_MAX, '0);
                    write_reg(irpd_pkg::CFG_ONE_THRESHOLD,    GAP_MAX);
                end
                4:
                begin
                    // NEC ratios on a random time base; unused indexes must be ignored
                    base = $urandom_range(20000, 1);
                    write_reg(irpd_pkg::CFG_TIMEOUT_GAP,
                              base * 30 + $urandom_range(base, 0));
                    write_reg(irpd_pkg::CFG_LEADER_MIN,       base * 8);
                    write_reg(irpd_pkg::CFG_LEADER_MAX,       base * 10);
                    write_reg(irpd_pkg::CFG_REPEAT_SPACE_MAX, base * 3);
                    write_reg(irpd_pkg::CFG_ONE_THRESHOLD,    base);
                    for (int idx = int'(irpd_pkg::CFG_ONE_THRESHOLD) + 1;
                         idx < 2 ** irpd_pkg::CFG_IDX_BITS; idx++)
                        write_reg(idx[irpd_pkg::CFG_IDX_BITS-1:0], $urandom);
                end
                5:
                begin
                    write_reg(irpd_pkg::CFG_TIMEOUT_GAP,      $urandom);
                    write_reg(irpd_pkg::CFG_LEADER_MIN,       $urandom);
                    write_reg(irpd_pkg::CFG_LEADER_MAX,       $urandom);
                    write_reg(irpd_pkg::CFG_REPEAT_SPACE_MAX, $urandom);
                    write_reg(irpd_pkg::CFG_ONE_THRESHOLD,    $urandom);
                end
                6:
                begin
                    write_reg(irpd_pkg::CFG_TIMEOUT_GAP,      irpd_pkg::RST_TIMEOUT_GAP);
                    write_reg(irpd_pkg::CFG_LEADER_MIN,       irpd_pkg::RST_LEADER_MIN);
                    write_reg(irpd_pkg::CFG_LEADER_MAX,       irpd_pkg::RST_LEADER_MAX);
                    write_reg(irpd_pkg::CFG_REPEAT_SPACE_MAX,
                              irpd_pkg::RST_REPEAT_SPACE_MAX);
                    write_reg(irpd_pkg::CFG_ONE_THRESHOLD,    irpd_pkg::RST_ONE_THRESHOLD);
                end
                default: ;
            endcase
            if (phase > 0)
                cfg_we <= 1'b0;
            // new random time base per phase, so the 48-bit wrap gets hit
            stim_time = {16'($urandom), $urandom};
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_frame();
            wait_idle();
        end

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            mismatches++;
        end
        $display("Ran %0d edges over %0d register settings, %0d results checked",
                 items_sent, NUM_PHASES, results_checked);
        $display("Seen: %0d new keys, %0d repeats, %0d check errors, %0d mismatches",
                 new_keys, repeat_keys, check_errs, mismatches);
        if (mismatches == 0)
        begin
            $display("PASS ir_pulse_distance_decoder_core");
        end
        else
        begin
            $display("FAIL ir_pulse_distance_decoder_core");
        end
        $finish;
    end

endmodule
